// ===== rtl/core/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lobm_pkg
// Shared sizes, command and status codes and the result row type of the
// price level order book core.
// ============================================================================
package lobm_pkg;

    localparam int LEVELS      = 64;
    localparam int TICK_W      = $clog2(LEVELS);
    localparam int LVL_AW      = TICK_W + 1;
    localparam int LVL_W       = 48;
    localparam int QTY_W       = 31;
    localparam int MAX_ORDERS  = 1024;
    localparam int ID_W        = $clog2(MAX_ORDERS);
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_MATCH  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic              is_fill;
        logic [TICK_W-1:0] tick;
        logic [QTY_W-1:0]  amount;
    } row_t;

endpackage

// ===== rtl/core/lobm_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lobm_cell
// One stage of the result chain: takes its neighbor's row on a pop and a new
// row when it is the write position.
// ============================================================================
module lobm_cell (
    input  logic          aclk,
    input  logic          pop,
    input  logic          load,
    input  lobm_pkg::row_t row_neighbor,
    input  lobm_pkg::row_t row_new,
    output lobm_pkg::row_t row_out
);

    lobm_pkg::row_t row_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            row_reg <= row_neighbor;
        end else if (load) begin
            row_reg <= row_new;
        end
    end

    assign row_out = row_reg;

endmodule

// ===== rtl/core/lobm_chain.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lobm_chain
// Row of result cells. Rows are written at the fill position and leave from
// cell zero, each pop moving every row one cell toward the head.
// ============================================================================
module lobm_chain (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  lobm_pkg::row_t             push_row,
    input  logic                       pop,
    output lobm_pkg::row_t             head_row,
    output logic [lobm_pkg::CNT_W-1:0] count
);

    localparam int DEPTH = lobm_pkg::MAX_RESULTS;

    lobm_pkg::row_t             cell_q [DEPTH];
    lobm_pkg::row_t             cell_n [DEPTH];
    logic [lobm_pkg::CNT_W-1:0] count_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign cell_n[i] = '0;
        end else begin : g_mid
            assign cell_n[i] = cell_q[i+1];
        end
        lobm_cell u_cell (
            .aclk         (aclk),
            .pop          (pop),
            .load         (push && (count_reg == lobm_pkg::CNT_W'(i))),
            .row_neighbor (cell_n[i]),
            .row_new      (push_row),
            .row_out      (cell_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (pop) begin
            count_reg <= count_reg - 1'b1;
        end else if (push) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign head_row = cell_q[0];
    assign count    = count_reg;

endmodule

// ===== rtl/core/limit_order_book_matcher_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// limit_order_book_matcher_core
// Price level order book with per tick bid and ask totals, an order table
// and a matcher that emits one fill per level walked.
// ============================================================================
//  Channel | Direction | Contents
//  s_      | in        | tuser cmd, tdata command fields
//  m_      | out       | tuser is_fill, tdata result fields, tlast end of command
//
//  An add that rests passes S_ADD_RD, a rejected one goes straight to S_DONE;
//  a live cancel passes S_CAN_RD and S_CAN_LVL, a dead id only S_CAN_RD and an
//  unused id neither; a match passes S_MT_SCAN and S_MT_FILL per fill, where the
//  registered level read issued in S_MT_SCAN feeds S_MT_FILL, then S_ADD_RD if a
//  remainder rests, or skips all when no id is left; S_DONE closes, S_DRAIN sends.
//  One command is in work at a time; s_tready is low until all its rows left.
//  A stalled m_ side holds the chain and the book unchanged.
//  Synchronous active low reset empties the book; no clearing pass is needed.
module limit_order_book_matcher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // cmd
    input  logic [63:0] s_tdata,   // side_is_bid, price_tick, quantity,
                                   // immediate_or_cancel, order_ref, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // is_fill
    output logic [79:0] m_tdata,   // status, assigned_id, taker id, fill_tick,
                                   // fill_amount, top_bid, top_ask,
                                   // book_crossed, zero pad
    output logic        m_tlast    // last
);

    localparam int TW  = lobm_pkg::TICK_W;
    localparam int AW  = lobm_pkg::LVL_AW;
    localparam int LW  = lobm_pkg::LVL_W;
    localparam int QW  = lobm_pkg::QTY_W;
    localparam int IW  = lobm_pkg::ID_W;
    localparam int NL  = lobm_pkg::LEVELS;
    localparam int CW  = lobm_pkg::CNT_W;

    typedef struct packed {
        logic          live;
        logic          side;
        logic [TW-1:0] tick;
        logic [QW-1:0] qty;
    } ord_t;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_RD, S_CAN_RD, S_CAN_LVL, S_MT_SCAN, S_MT_FILL, S_DONE, S_DRAIN
    } state_t;

    state_t         state_reg;
    logic           side_reg, ioc_reg, match_reg;
    logic [15:0]    tick_reg;
    logic [QW-1:0]  qty_reg;
    logic [IW-1:0]  ref_reg, aid_reg, tid_reg;
    logic [1:0]     status_reg;
    logic [CW-1:0]  nfill_reg;
    logic [IW:0]    next_id_reg;
    logic [2*NL-1:0] nz_reg;
    logic [AW-1:0]  lvl_addr_reg;

    logic [LW-1:0]  lvl_mem [2*NL];
    logic [LW-1:0]  lvl_rd_reg;
    ord_t           ord_mem [lobm_pkg::MAX_ORDERS];
    ord_t           ord_rd_reg;

    logic           lvl_re, lvl_we, ord_re, ord_we, nz_val, push;
    logic [AW-1:0]  lvl_rd_addr, lvl_wr_addr;
    logic [LW-1:0]  lvl_wr_data, lvl_cur, sub, traded;
    logic [IW-1:0]  ord_rd_addr, ord_wr_addr;
    ord_t           ord_wr_data;
    lobm_pkg::row_t push_row, head_row;
    logic [CW-1:0]  count;
    logic           pop, accept, s_side, s_ioc, in_range_s, in_range_r;
    logic [15:0]    s_tick;
    logic [QW-1:0]  s_qty;
    logic [IW-1:0]  s_ref;
    logic [LW:0]    add_sum;
    logic           add_ok, hit, scan_go, rest_go;
    logic [TW-1:0]  px;
    logic [6:0]     bid_top_tick, ask_top_tick;
    logic           crossed, last_row;

    function automatic logic [6:0] top_of_bids(input logic [NL-1:0] v);
        logic [6:0] r;
        r = 7'h7F;
        for (int i = 0; i < NL; i++) begin
            if (v[i]) r = 7'(i);
        end
        return r;
    endfunction

    function automatic logic [6:0] top_of_asks(input logic [NL-1:0] v);
        logic [6:0] r;
        r = 7'(NL);
        for (int i = NL - 1; i >= 0; i--) begin
            if (v[i]) r = 7'(i);
        end
        return r;
    endfunction

    assign s_side     = s_tdata[0];
    assign s_tick     = s_tdata[16:1];
    assign s_qty      = s_tdata[47:17];
    assign s_ioc      = s_tdata[48];
    assign s_ref      = s_tdata[58:49];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_range_s = (s_tick[15:TW] == '0);
    assign in_range_r = (tick_reg[15:TW] == '0);

    assign bid_top_tick = top_of_bids(nz_reg[2*NL-1:NL]);
    assign ask_top_tick = top_of_asks(nz_reg[NL-1:0]);
    assign crossed  = !bid_top_tick[6] && !ask_top_tick[6]
                   && (bid_top_tick[5:0] >= ask_top_tick[5:0]);

    assign lvl_cur = nz_reg[lvl_addr_reg] ? lvl_rd_reg : '0;
    assign add_sum = {1'b0, lvl_cur} + {{(LW-QW+1){1'b0}}, qty_reg};
    assign add_ok  = !add_sum[LW] && !next_id_reg[IW];
    assign sub     = ({{(LW-QW){1'b0}}, ord_rd_reg.qty} > lvl_cur) ? lvl_cur
                   : {{(LW-QW){1'b0}}, ord_rd_reg.qty};
    assign traded  = ({{(LW-QW){1'b0}}, qty_reg} < lvl_cur) ? {{(LW-QW){1'b0}}, qty_reg}
                   : lvl_cur;

    always_comb begin
        if (side_reg) begin
            hit = !ask_top_tick[6] && ($signed({10'd0, ask_top_tick})
                                       <= $signed({tick_reg[15], tick_reg}));
            px  = ask_top_tick[TW-1:0];
        end else begin
            hit = !bid_top_tick[6] && ($signed({{10{bid_top_tick[6]}}, bid_top_tick})
                                       >= $signed({tick_reg[15], tick_reg}));
            px  = bid_top_tick[TW-1:0];
        end
    end

    assign scan_go = (qty_reg != '0) && !nfill_reg[CW-1] && hit;
    assign rest_go = (qty_reg != '0) && !ioc_reg && in_range_r;

    always_comb begin
        lvl_re      = 1'b0;
        lvl_rd_addr = lvl_addr_reg;
        lvl_we      = 1'b0;
        lvl_wr_addr = lvl_addr_reg;
        lvl_wr_data = add_sum[LW-1:0];
        nz_val      = 1'b1;
        ord_re      = 1'b0;
        ord_rd_addr = s_ref;
        ord_we      = 1'b0;
        ord_wr_addr = next_id_reg[IW-1:0];
        ord_wr_data = '{live: 1'b1, side: side_reg, tick: tick_reg[TW-1:0], qty: qty_reg};
        push        = 1'b0;
        push_row    = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        lobm_pkg::CMD_ADD: begin
                            lvl_re      = in_range_s && (s_qty != '0);
                            lvl_rd_addr = {s_side, s_tick[TW-1:0]};
                        end
                        lobm_pkg::CMD_CANCEL: begin
                            ord_re = ({1'b0, s_ref} < next_id_reg);
                        end
                        lobm_pkg::CMD_MATCH: begin
                            ord_we      = !next_id_reg[IW];
                            ord_wr_data = '{live: 1'b0, side: s_side,
                                            tick: s_tick[TW-1:0], qty: '0};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                lvl_we = add_ok;
                ord_we = add_ok;
            end
            S_CAN_RD: begin
                lvl_re      = ord_rd_reg.live;
                lvl_rd_addr = {ord_rd_reg.side, ord_rd_reg.tick};
                ord_we      = ord_rd_reg.live;
                ord_wr_addr = ref_reg;
                ord_wr_data = '{live: 1'b0, side: ord_rd_reg.side,
                                tick: ord_rd_reg.tick, qty: ord_rd_reg.qty};
            end
            S_CAN_LVL: begin
                lvl_we      = 1'b1;
                lvl_wr_data = lvl_cur - sub;
                nz_val      = (lvl_cur != sub);
            end
            S_MT_SCAN: begin
                lvl_re      = scan_go || rest_go;
                lvl_rd_addr = scan_go ? {!side_reg, px} : {side_reg, tick_reg[TW-1:0]};
            end
            S_MT_FILL: begin
                lvl_we      = 1'b1;
                lvl_wr_data = lvl_cur - traded;
                nz_val      = (lvl_cur != traded);
                push        = 1'b1;
                push_row    = '{is_fill: 1'b1, tick: lvl_addr_reg[TW-1:0],
                                amount: traded[QW-1:0]};
            end
            S_DONE: begin
                push = !(match_reg && (nfill_reg != '0));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_wr_addr] <= lvl_wr_data;
        end
        if (lvl_re) begin
            lvl_rd_reg <= lvl_mem[lvl_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_wr_addr] <= ord_wr_data;
        end
        if (ord_re) begin
            ord_rd_reg <= ord_mem[ord_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            next_id_reg <= '0;
            nz_reg      <= '0;
            nfill_reg   <= '0;
        end else begin
            if (lvl_we) begin
                nz_reg[lvl_wr_addr] <= nz_val;
            end
            if (lvl_re) begin
                lvl_addr_reg <= lvl_rd_addr;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        side_reg   <= s_side;
                        tick_reg   <= s_tick;
                        qty_reg    <= s_qty;
                        ioc_reg    <= s_ioc;
                        ref_reg    <= s_ref;
                        status_reg <= lobm_pkg::ST_REJECT;
                        aid_reg    <= '0;
                        tid_reg    <= '0;
                        nfill_reg  <= '0;
                        match_reg  <= (s_tuser == lobm_pkg::CMD_MATCH);
                        state_reg  <= S_DONE;
                        case (s_tuser)
                            lobm_pkg::CMD_ADD: begin
                                if (in_range_s && (s_qty != '0)) state_reg <= S_ADD_RD;
                            end
                            lobm_pkg::CMD_CANCEL: begin
                                if ({1'b0, s_ref} < next_id_reg) state_reg <= S_CAN_RD;
                            end
                            lobm_pkg::CMD_MATCH: begin
                                if (next_id_reg[IW]) begin
                                    status_reg <= lobm_pkg::ST_FULL;
                                end else begin
                                    tid_reg     <= next_id_reg[IW-1:0];
                                    next_id_reg <= next_id_reg + 1'b1;
                                    state_reg   <= S_MT_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADD_RD: begin
                    if (add_sum[LW]) begin
                        status_reg <= lobm_pkg::ST_REJECT;
                    end else if (next_id_reg[IW]) begin
                        status_reg <= lobm_pkg::ST_FULL;
                    end else begin
                        status_reg  <= lobm_pkg::ST_OK;
                        aid_reg     <= next_id_reg[IW-1:0];
                        next_id_reg <= next_id_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_CAN_RD: begin
                    state_reg <= ord_rd_reg.live ? S_CAN_LVL : S_DONE;
                end
                S_CAN_LVL: begin
                    status_reg <= lobm_pkg::ST_OK;
                    state_reg  <= S_DONE;
                end
                S_MT_SCAN: begin
                    if (scan_go) begin
                        state_reg <= S_MT_FILL;
                    end else if (rest_go) begin
                        state_reg <= S_ADD_RD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_MT_FILL: begin
                    qty_reg   <= qty_reg - traded[QW-1:0];
                    nfill_reg <= nfill_reg + 1'b1;
                    state_reg <= S_MT_SCAN;
                end
                S_DONE: begin
                    state_reg <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (pop && (count == CW'(1))) state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    lobm_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_row (push_row),
        .pop      (pop),
        .head_row (head_row),
        .count    (count)
    );

    assign m_tvalid = (state_reg == S_DRAIN);
    assign pop      = m_tvalid && m_tready;
    assign last_row = (count == CW'(1));
    assign m_tlast  = last_row;
    assign m_tuser  = head_row.is_fill;
    assign m_tdata  = {6'd0, crossed, ask_top_tick, bid_top_tick, head_row.amount,
                       head_row.tick, tid_reg, last_row ? aid_reg : {IW{1'b0}},
                       last_row ? status_reg : lobm_pkg::ST_OK};

    a_busy_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while results are pending");

    a_ids_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg <= (IW+1)'(lobm_pkg::MAX_ORDERS))
        else $error("order id counter passed the table size");

    a_fills_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        nfill_reg <= CW'(lobm_pkg::MAX_RESULTS))
        else $error("too many fills for one command");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> (count != '0))
        else $error("command closed without a result row");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && m_tlast) |=> s_tready)
        else $error("not ready after the final row");

endmodule

// ===== sim/limit_order_book_matcher_core_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// limit_order_book_matcher_core_checker
// Watches both channels of the order book core, keeps its own copy of the
// book, and compares every result transaction with the predicted rows.
// ============================================================================
module limit_order_book_matcher_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        m_tuser,
    input  logic [79:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          rows_pending
);

    localparam int LW = lobm_pkg::LVL_W;
    localparam int NL = lobm_pkg::LEVELS;
    localparam int NO = lobm_pkg::MAX_ORDERS;
    localparam int NR = lobm_pkg::MAX_RESULTS;

    typedef struct {
        logic        is_fill;
        logic [1:0]  status;
        logic [9:0]  new_id;
        logic [9:0]  taker;
        logic [5:0]  tick;
        logic [30:0] amount;
        logic [6:0]  bid_top;
        logic [6:0]  ask_top;
        logic        crossed;
        logic        last;
    } book_row_t;

    logic [LW-1:0]    bid_depth [NL];
    logic [LW-1:0]    ask_depth [NL];
    int               hi_bid;
    int               lo_ask;
    logic             ord_is_bid [NO];
    int               ord_tick   [NO];
    logic [30:0]      ord_qty    [NO];
    logic             ord_live   [NO];
    int               id_next;
    book_row_t        expected_rows [$];

    assign rows_pending = expected_rows.size();

    function automatic void move_best(logic is_bid, int tick);
        if (is_bid && tick == hi_bid) begin
            while (hi_bid >= 0 && bid_depth[hi_bid] == 0) hi_bid--;
        end
        if (!is_bid && tick == lo_ask) begin
            while (lo_ask < NL && ask_depth[lo_ask] == 0) lo_ask++;
        end
    endfunction

    function automatic logic [1:0] rest_order(logic is_bid, int tick, logic [30:0] qty,
                                              output logic [9:0] id);
        logic [LW-1:0] room;
        id = '0;
        if (tick < 0 || tick >= NL || qty == 0) return lobm_pkg::ST_REJECT;
        room = {LW{1'b1}} - (is_bid ? bid_depth[tick] : ask_depth[tick]);
        if (LW'(qty) > room) return lobm_pkg::ST_REJECT;
        if (id_next >= NO) return lobm_pkg::ST_FULL;
        if (is_bid) begin
            bid_depth[tick] += LW'(qty);
            if (tick > hi_bid) hi_bid = tick;
        end else begin
            ask_depth[tick] += LW'(qty);
            if (tick < lo_ask) lo_ask = tick;
        end
        id = id_next[9:0];
        ord_is_bid[id_next] = is_bid;
        ord_tick[id_next] = tick;
        ord_qty[id_next] = qty;
        ord_live[id_next] = 1'b1;
        id_next++;
        return lobm_pkg::ST_OK;
    endfunction

    function automatic void predict(logic [1:0] cmd, logic [63:0] f);
        logic          is_bid;
        int            tick;
        logic [30:0]   qty;
        logic          ioc;
        int            ref_id;
        logic [1:0]    status;
        logic [9:0]    new_id;
        logic [9:0]    taker;
        book_row_t     rows [$];
        book_row_t     r;
        int            px;
        logic [LW-1:0] avail;
        logic [LW-1:0] traded;
        logic          crossed;
        is_bid = f[0];
        tick = int'($signed(f[16:1]));
        qty = f[47:17];
        ioc = f[48];
        ref_id = int'(f[58:49]);
        status = lobm_pkg::ST_REJECT;
        new_id = '0;
        taker = '0;
        if (cmd == lobm_pkg::CMD_ADD) begin
            status = rest_order(is_bid, tick, qty, new_id);
        end else if (cmd == lobm_pkg::CMD_CANCEL) begin
            if (ord_live[ref_id]) begin
                ord_live[ref_id] = 1'b0;
                if (ord_is_bid[ref_id]) begin
                    avail = bid_depth[ord_tick[ref_id]];
                    traded = LW'(ord_qty[ref_id]) > avail ? avail : LW'(ord_qty[ref_id]);
                    bid_depth[ord_tick[ref_id]] -= traded;
                end else begin
                    avail = ask_depth[ord_tick[ref_id]];
                    traded = LW'(ord_qty[ref_id]) > avail ? avail : LW'(ord_qty[ref_id]);
                    ask_depth[ord_tick[ref_id]] -= traded;
                end
                move_best(ord_is_bid[ref_id], ord_tick[ref_id]);
                status = lobm_pkg::ST_OK;
            end
        end else if (cmd == lobm_pkg::CMD_MATCH) begin
            if (id_next >= NO) begin
                status = lobm_pkg::ST_FULL;
            end else begin
                taker = id_next[9:0];
                ord_live[id_next] = 1'b0;
                id_next++;
                while (qty > 0 && rows.size() < NR) begin
                    px = is_bid ? lo_ask : hi_bid;
                    if (is_bid ? !(px <= tick && px < NL) : !(px >= tick && px >= 0))
                        break;
                    avail = is_bid ? ask_depth[px] : bid_depth[px];
                    traded = LW'(qty) < avail ? LW'(qty) : avail;
                    if (is_bid) ask_depth[px] -= traded;
                    else bid_depth[px] -= traded;
                    qty -= traded[30:0];
                    r = '{default: '0};
                    r.is_fill = 1'b1;
                    r.tick = px[5:0];
                    r.amount = traded[30:0];
                    rows = {rows, r};
                    if ((is_bid ? ask_depth[px] : bid_depth[px]) == 0) move_best(!is_bid, px);
                end
                status = lobm_pkg::ST_REJECT;
                if (qty > 0 && !ioc) status = rest_order(is_bid, tick, qty, new_id);
            end
        end
        if (rows.size() == 0) begin
            r = '{default: '0};
            rows = {r};
        end
        rows[$].status = status;
        rows[$].new_id = new_id;
        rows[$].last = 1'b1;
        crossed = hi_bid >= 0 && lo_ask < NL && hi_bid >= lo_ask;
        foreach (rows[k]) begin
            rows[k].taker = taker;
            rows[k].bid_top = hi_bid[6:0];
            rows[k].ask_top = lo_ask[6:0];
            rows[k].crossed = crossed;
            expected_rows = {expected_rows, rows[k]};
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        mismatches = 0;
        foreach (bid_depth[i]) begin
            bid_depth[i] = '0;
            ask_depth[i] = '0;
        end
        foreach (ord_live[i]) ord_live[i] = 1'b0;
        hi_bid = -1;
        lo_ask = NL;
        id_next = 0;
    end

    always @(posedge aclk) begin
        book_row_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rows.size() == 0) begin
                $error("result transaction with no expected row");
                mismatches++;
            end else begin
                want = expected_rows.pop_front();
                check_field("is_fill", want.is_fill, m_tuser);
                check_field("status", want.status, m_tdata[1:0]);
                check_field("assigned_id", want.new_id, m_tdata[11:2]);
                check_field("taker_order_id", want.taker, m_tdata[21:12]);
                check_field("fill_tick", want.tick, m_tdata[27:22]);
                check_field("fill_amount", want.amount, m_tdata[58:28]);
                check_field("top_bid", $signed(want.bid_top), $signed(m_tdata[65:59]));
                check_field("top_ask", want.ask_top, m_tdata[72:66]);
                check_field("book_crossed", want.crossed, m_tdata[73]);
                check_field("last", want.last, m_tlast);
            end
        end
        if (aresetn && s_tvalid && s_tready) predict(s_tuser, s_tdata);
    end

endmodule

// ===== sim/limit_order_book_matcher_core_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// limit_order_book_matcher_core_test
// Drives directed and random add, cancel and match commands into the order
// book core under varying stalls on both sides.
// ============================================================================
module limit_order_book_matcher_core_test;

    localparam logic [1:0] CMD_ADD     = lobm_pkg::CMD_ADD;
    localparam logic [1:0] CMD_CANCEL  = lobm_pkg::CMD_CANCEL;
    localparam logic [1:0] CMD_MATCH   = lobm_pkg::CMD_MATCH;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tuser;
    logic [79:0] m_tdata;
    logic        m_tlast;
    int          mismatches;
    int          rows_pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_request;
    int          cycles;

    limit_order_book_matcher_core dut (.*);

    limit_order_book_matcher_core_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int hold_left;
        bit hold_armed;
        m_tready = 1'b0;
        hold_left = 0;
        hold_armed = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_request && hold_armed) begin
                hold_left = 400;
                hold_armed = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= recv_idle_pct;
            end
        end
    end

    task automatic send(logic [1:0] cmd, logic is_bid, logic [15:0] tick, logic [30:0] qty,
                        logic ioc, logic [9:0] ref_id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, ref_id, ioc, qty, tick, is_bid};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random();
        int          pick;
        logic [1:0]  cmd;
        logic [15:0] tick;
        logic [30:0] qty;
        logic [9:0]  ref_id;
        pick = $urandom_range(99);
        cmd = pick < 45 ? CMD_ADD : pick < 75 ? CMD_MATCH : pick < 95 ? CMD_CANCEL : CMD_UNUSED;
        tick = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(63));
        pick = $urandom_range(19);
        qty = pick == 0 ? 31'd0 : pick == 1 ? 31'($urandom) : 31'($urandom_range(1, 2000));
        ref_id = $urandom_range(7) == 0 ? 10'($urandom) : 10'($urandom_range(300));
        send(cmd, 1'($urandom_range(1)), tick, qty, $urandom_range(3) == 0, ref_id);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = CMD_ADD;
        s_tdata = '0;
        hold_request = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 49;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send(CMD_ADD, 1'b1, 16'd0, 31'h7FFF_FFFF, 1'b0, 10'd0);
        send(CMD_ADD, 1'b0, 16'd63, 31'd1, 1'b0, 10'd0);
        send(CMD_ADD, 1'b1, 16'hFFFF, 31'd5, 1'b0, 10'd0);
        send(CMD_ADD, 1'b0, 16'd64, 31'd5, 1'b0, 10'd0);
        send(CMD_ADD, 1'b1, 16'h8000, 31'd5, 1'b0, 10'd0);
        send(CMD_ADD, 1'b0, 16'h7FFF, 31'd5, 1'b0, 10'd0);
        send(CMD_ADD, 1'b1, 16'd10, 31'd0, 1'b0, 10'd0);
        send(CMD_ADD, 1'b0, 16'd20, 31'd40, 1'b0, 10'd0);
        send(CMD_ADD, 1'b0, 16'd21, 31'd30, 1'b0, 10'd0);
        send(CMD_ADD, 1'b1, 16'd15, 31'd25, 1'b0, 10'd0);
        send(CMD_CANCEL, 1'b0, 16'd0, 31'd0, 1'b0, 10'd1);
        send(CMD_CANCEL, 1'b0, 16'd0, 31'd0, 1'b0, 10'd1);
        send(CMD_CANCEL, 1'b0, 16'd0, 31'd0, 1'b0, 10'h3FF);
        send(CMD_MATCH, 1'b1, 16'd25, 31'd50, 1'b0, 10'd0);
        send(CMD_MATCH, 1'b1, 16'd40, 31'd100, 1'b1, 10'd0);
        send(CMD_MATCH, 1'b0, 16'd0, 31'd10, 1'b0, 10'd0);
        send(CMD_MATCH, 1'b0, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 10'd0);
        send(CMD_MATCH, 1'b1, 16'd30, 31'd0, 1'b0, 10'd0);
        send(CMD_MATCH, 1'b0, 16'd63, 31'd7, 1'b0, 10'd0);
        send(CMD_UNUSED, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 10'h3FF);
        for (int i = 0; i < 64; i++) send(CMD_ADD, 1'b0, 16'(i), 31'd3, 1'b0, 10'd0);
        send(CMD_MATCH, 1'b1, 16'h7FFF, 31'h7FFF_FFFF, 1'b0, 10'd0);

        for (int i = 0; i < 165; i++) begin
            if (i == 55) begin
                send_idle_pct = 49;
                recv_idle_pct = 23;
            end
            if (i == 110) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request <= 1'b1;
            end
            if (i == 111) hold_request <= 1'b0;
            send_random();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lobm_pkg.sv
rtl/core/lobm_cell.sv
rtl/core/lobm_chain.sv
rtl/core/limit_order_book_matcher_core.sv
sim/limit_order_book_matcher_core_checker.sv
sim/limit_order_book_matcher_core_test.sv
